### sv/sbba_pkg.sv
// Shared types, constants and saturating arithmetic for the bounding box accumulator.
package sbba_pkg;

    // Coordinate format: signed Q24.8
    localparam int COORD_BITS = 32;
    localparam int CFG_BITS   = 20;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [CFG_BITS-1:0]          cfg_val_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Register reset values: 50.0 and 10.0 in Q24.8
    localparam cfg_val_t TEXT_W_RESET = CFG_BITS'(12800);
    localparam cfg_val_t TEXT_H_RESET = CFG_BITS'(2560);

    // Shape kind codes
    localparam logic [2:0] KIND_CLEAR  = 3'd0;
    localparam logic [2:0] KIND_CIRCLE = 3'd1;
    localparam logic [2:0] KIND_RECT   = 3'd2;
    localparam logic [2:0] KIND_LINE   = 3'd3;
    localparam logic [2:0] KIND_TEXT   = 3'd4;
    localparam logic [2:0] KIND_POINT  = 3'd5;

    // Action applied to the running box
    typedef enum logic [1:0] {
        OP_IGNORE,
        OP_CLEAR,
        OP_TAKE
    } box_op_t;

    typedef struct packed {
        logic [2:0] kind;
        coord_t     coord_a;
        coord_t     coord_b;
        coord_t     coord_c;
        coord_t     coord_d;
    } shape_in_t;

    typedef struct packed {
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_max_x;
        coord_t box_max_y;
        logic   box_empty;
    } box_out_t;

    // Extents of one shape, passed from the extent stage to the box stage
    typedef struct packed {
        box_op_t op;
        coord_t  lo_x;
        coord_t  lo_y;
        coord_t  hi_x;
        coord_t  hi_y;
    } extent_t;

    // Saturating add
    function automatic coord_t sat_add(input coord_t a, input coord_t b);
        logic signed [COORD_BITS:0] sum;
        sum = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
        if (sum[COORD_BITS] != sum[COORD_BITS-1]) begin
            return sum[COORD_BITS] ? COORD_MIN : COORD_MAX;
        end
        return sum[COORD_BITS-1:0];
    endfunction

    // Saturating subtract
    function automatic coord_t sat_sub(input coord_t a, input coord_t b);
        logic signed [COORD_BITS:0] diff;
        diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        if (diff[COORD_BITS] != diff[COORD_BITS-1]) begin
            return diff[COORD_BITS] ? COORD_MIN : COORD_MAX;
        end
        return diff[COORD_BITS-1:0];
    endfunction

endpackage

### sv/sbba_regs.sv
// APB configuration registers holding the estimated text extents.
module sbba_regs (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output sbba_pkg::cfg_val_t    text_w,
    output sbba_pkg::cfg_val_t    text_h
);

    localparam logic REG_TEXT_W = 1'b0;
    localparam logic REG_TEXT_H = 1'b1;

    sbba_pkg::cfg_val_t text_w_reg;
    sbba_pkg::cfg_val_t text_h_reg;
    logic               wr_en;
    logic               reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_w_reg <= sbba_pkg::TEXT_W_RESET;
            text_h_reg <= sbba_pkg::TEXT_H_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TEXT_W: text_w_reg <= pwdata[sbba_pkg::CFG_BITS-1:0];
                REG_TEXT_H: text_h_reg <= pwdata[sbba_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        unique case (reg_idx)
            REG_TEXT_W: prdata = {{(32-sbba_pkg::CFG_BITS){1'b0}}, text_w_reg};
            REG_TEXT_H: prdata = {{(32-sbba_pkg::CFG_BITS){1'b0}}, text_h_reg};
            default:    prdata = '0;
        endcase
    end

    assign text_w = text_w_reg;
    assign text_h = text_h_reg;

endmodule

### sv/sbba_extent.sv
// Input register and per-shape extent calculation, registered for the box stage.
module sbba_extent (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sbba_pkg::shape_in_t   s_item,
    input  sbba_pkg::cfg_val_t    text_w,
    input  sbba_pkg::cfg_val_t    text_h,
    output logic                  ext_valid,
    input  logic                  ext_take,
    output sbba_pkg::extent_t     ext
);

    logic                in_valid_reg;
    sbba_pkg::shape_in_t in_item_reg;
    logic                ext_valid_reg;
    sbba_pkg::extent_t   ext_reg;
    sbba_pkg::extent_t   ext_next;
    logic                ext_ready;
    sbba_pkg::coord_t    text_w_c;
    sbba_pkg::coord_t    text_h_c;

    assign ext_ready = !ext_valid_reg || ext_take;
    assign s_ready   = !in_valid_reg || ext_ready;

    assign text_w_c = {{(sbba_pkg::COORD_BITS-sbba_pkg::CFG_BITS){1'b0}}, text_w};
    assign text_h_c = {{(sbba_pkg::COORD_BITS-sbba_pkg::CFG_BITS){1'b0}}, text_h};

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Extents of the shape held in the input register
    always_comb begin
        ext_next.op   = sbba_pkg::OP_TAKE;
        ext_next.lo_x = in_item_reg.coord_a;
        ext_next.lo_y = in_item_reg.coord_b;
        ext_next.hi_x = in_item_reg.coord_a;
        ext_next.hi_y = in_item_reg.coord_b;
        unique case (in_item_reg.kind)
            sbba_pkg::KIND_CLEAR: begin
                ext_next.op = sbba_pkg::OP_CLEAR;
            end
            sbba_pkg::KIND_CIRCLE: begin
                ext_next.lo_x = sbba_pkg::sat_sub(in_item_reg.coord_a, in_item_reg.coord_c);
                ext_next.lo_y = sbba_pkg::sat_sub(in_item_reg.coord_b, in_item_reg.coord_c);
                ext_next.hi_x = sbba_pkg::sat_add(in_item_reg.coord_a, in_item_reg.coord_c);
                ext_next.hi_y = sbba_pkg::sat_add(in_item_reg.coord_b, in_item_reg.coord_c);
            end
            sbba_pkg::KIND_RECT: begin
                ext_next.hi_x = sbba_pkg::sat_add(in_item_reg.coord_a, in_item_reg.coord_c);
                ext_next.hi_y = sbba_pkg::sat_add(in_item_reg.coord_b, in_item_reg.coord_d);
            end
            sbba_pkg::KIND_LINE: begin
                if (in_item_reg.coord_c < in_item_reg.coord_a) begin
                    ext_next.lo_x = in_item_reg.coord_c;
                end else begin
                    ext_next.hi_x = in_item_reg.coord_c;
                end
                if (in_item_reg.coord_d < in_item_reg.coord_b) begin
                    ext_next.lo_y = in_item_reg.coord_d;
                end else begin
                    ext_next.hi_y = in_item_reg.coord_d;
                end
            end
            sbba_pkg::KIND_TEXT: begin
                ext_next.hi_x = sbba_pkg::sat_add(in_item_reg.coord_a, text_w_c);
                ext_next.hi_y = sbba_pkg::sat_add(in_item_reg.coord_b, text_h_c);
            end
            sbba_pkg::KIND_POINT: begin
                ext_next.op = sbba_pkg::OP_TAKE;
            end
            default: begin
                // unused kinds leave the box alone
                ext_next.op = sbba_pkg::OP_IGNORE;
            end
        endcase
    end

    // Extent register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_valid_reg <= 1'b0;
        end else if (ext_ready) begin
            ext_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ext_ready && in_valid_reg) begin
            ext_reg <= ext_next;
        end
    end

    assign ext_valid = ext_valid_reg;
    assign ext       = ext_reg;

endmodule

### sv/sbba_box.sv
// Running bounding box state and the result register.
module sbba_box (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ext_valid,
    output logic                  ext_take,
    input  sbba_pkg::extent_t     ext,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sbba_pkg::box_out_t    m_item
);

    sbba_pkg::coord_t   least_x_reg, least_x_next;
    sbba_pkg::coord_t   least_y_reg, least_y_next;
    sbba_pkg::coord_t   greatest_x_reg, greatest_x_next;
    sbba_pkg::coord_t   greatest_y_reg, greatest_y_next;
    logic               empty_reg, empty_next;
    logic               m_valid_reg;
    sbba_pkg::box_out_t m_item_reg;

    assign ext_take = ext_valid && (!m_valid_reg || m_ready);

    // Box update for the extent at the head of the pipe
    always_comb begin
        least_x_next    = least_x_reg;
        least_y_next    = least_y_reg;
        greatest_x_next = greatest_x_reg;
        greatest_y_next = greatest_y_reg;
        empty_next      = empty_reg;
        case (ext.op)
            sbba_pkg::OP_CLEAR: begin
                least_x_next    = sbba_pkg::COORD_MAX;
                least_y_next    = sbba_pkg::COORD_MAX;
                greatest_x_next = sbba_pkg::COORD_MIN;
                greatest_y_next = sbba_pkg::COORD_MIN;
                empty_next      = 1'b1;
            end
            sbba_pkg::OP_TAKE: begin
                if (ext.lo_x < least_x_reg)    least_x_next    = ext.lo_x;
                if (ext.lo_y < least_y_reg)    least_y_next    = ext.lo_y;
                if (ext.hi_x > greatest_x_reg) greatest_x_next = ext.hi_x;
                if (ext.hi_y > greatest_y_reg) greatest_y_next = ext.hi_y;
                empty_next = 1'b0;
            end
            default: ;
        endcase
    end

    // Box state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            least_x_reg    <= sbba_pkg::COORD_MAX;
            least_y_reg    <= sbba_pkg::COORD_MAX;
            greatest_x_reg <= sbba_pkg::COORD_MIN;
            greatest_y_reg <= sbba_pkg::COORD_MIN;
            empty_reg      <= 1'b1;
        end else if (ext_take) begin
            least_x_reg    <= least_x_next;
            least_y_reg    <= least_y_next;
            greatest_x_reg <= greatest_x_next;
            greatest_y_reg <= greatest_y_next;
            empty_reg      <= empty_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ext_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ext_take) begin
            m_item_reg.box_min_x <= least_x_next;
            m_item_reg.box_min_y <= least_y_next;
            m_item_reg.box_max_x <= greatest_x_next;
            m_item_reg.box_max_y <= greatest_y_next;
            m_item_reg.box_empty <= empty_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // An empty box always reads as the inverted reset box
    a_empty_box: assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg |-> (least_x_reg == sbba_pkg::COORD_MAX)
                   && (greatest_y_reg == sbba_pkg::COORD_MIN))
        else $error("empty box holds non-reset extremes");

    // A pending result matches the box state it was taken from
    a_result_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_item_reg.box_min_x == least_x_reg)
                     && (m_item_reg.box_max_y == greatest_y_reg)
                     && (m_item_reg.box_empty == empty_reg))
        else $error("result register out of step with box state");

    // Adding a shape marks the box non-empty
    a_take_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (ext_take && ext.op == sbba_pkg::OP_TAKE) |=> !empty_reg)
        else $error("box still empty after a shape was added");

    // Minimum only moves up through a clear
    a_min_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ext_take && ext.op == sbba_pkg::OP_CLEAR)
            |=> ($signed(least_x_reg) <= $signed($past(least_x_reg))))
        else $error("least x rose without a clear");

endmodule

### sv/shape_bounding_box_accumulator_top.sv
// Top level of the shape bounding box accumulator.
//
//   Channel   Ports                         Direction   Transaction
//   s_        s_valid/s_ready/s_item        in          one shape
//   m_        m_valid/m_ready/m_item        out         box after that shape
//   APB       psel..pready                  in/out      text extent registers
//
// One shape per cycle sustained while m_ready stays high; each result passes through
// the input register, extent register and result register after its shape is taken.
// The box compare-and-update is the only loop.
// aresetn is synchronous: box returns to empty, text extents to 50.0 x 10.0.
// A stalled m_ready backs the three stages up in turn; s_ready drops only
// once all are full.
module shape_bounding_box_accumulator_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sbba_pkg::shape_in_t   s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sbba_pkg::box_out_t    m_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    sbba_pkg::cfg_val_t text_w;
    sbba_pkg::cfg_val_t text_h;
    logic               ext_valid;
    logic               ext_take;
    sbba_pkg::extent_t  ext;

    sbba_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .text_w  (text_w),
        .text_h  (text_h)
    );

    sbba_extent u_extent (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .text_w    (text_w),
        .text_h    (text_h),
        .ext_valid (ext_valid),
        .ext_take  (ext_take),
        .ext       (ext)
    );

    sbba_box u_box (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ext_valid (ext_valid),
        .ext_take  (ext_take),
        .ext       (ext),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
